>>> src/trvs_pkg.sv
// Package: shared types and constants for the RRIP victim select block.
`timescale 1ns / 1ps
package trvs_pkg;
  localparam int unsigned Ways   = 16;
  localparam int unsigned WayW   = $clog2(Ways);
  localparam int unsigned RrpvW  = 4;

  typedef enum logic [1:0] {
    OP_HIT   = 2'd0,
    OP_FILL  = 2'd1,
    OP_INVAL = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    MODE_PTR    = 2'd0,
    MODE_COMB   = 2'd1,
    MODE_DEGREE = 2'd2,
    MODE_HINT   = 2'd3
  } mode_e;

  localparam logic [0:0] CFG_MODE = 1'b0;
  localparam logic [0:0] CFG_BITS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_AGE,
    ST_WRITE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] target_way;
    logic       is_property;
    logic [1:0] grasp_tier;
    logic [3:0] degree_tier;
    logic [3:0] reuse_hint;
  } in_item_t;

  typedef struct packed {
    logic [3:0] chosen_way;
    logic       was_invalid;
    logic [3:0] prior_rrpv;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input item
    logic exec;     // hit/inval update, fill: invalid check
    logic scan;     // one probe of the scan
    logic age;      // age all ways
    logic write;    // commit fill
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_fill;
    logic has_inval;
    logic found;     // scan hit a max way
    logic scan_end;  // last probe of a sweep
  } dp_sts_t;
endpackage

>>> src/trvs_if.sv
// Interfaces: valid/ready channels for items and configuration writes.
`timescale 1ns / 1ps
interface trvs_in_if import trvs_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface trvs_out_if import trvs_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface trvs_cfg_if ();
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> src/trvs_ctrl.sv
// Controller: sequences hit, fill search, aging and result transfer.
`timescale 1ns / 1ps
module trvs_ctrl import trvs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: begin
        if (!sts_i.is_fill || sts_i.has_inval) state_d = sts_i.is_fill ? ST_WRITE : ST_OUT;
        else state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.found) state_d = ST_WRITE;
        else if (sts_i.scan_end) state_d = ST_AGE;
      end
      ST_AGE:   state_d = ST_SCAN;
      ST_WRITE: state_d = ST_OUT;
      ST_OUT:   if (out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EXEC:  cmd_o.exec = 1'b1;
      ST_SCAN:  cmd_o.scan = 1'b1;
      ST_AGE:   cmd_o.age = 1'b1;
      ST_WRITE: cmd_o.write = 1'b1;
      ST_OUT:   out_valid_o = 1'b1;
      default: ;
    endcase
  end
endmodule

>>> src/trvs_dp.sv
// Datapath: per-way tables, victim scan, aging and insertion value.
`timescale 1ns / 1ps
module trvs_dp import trvs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  in_item_t   in_data_i,
  input  dp_cmd_t    cmd_i,
  output dp_sts_t    sts_o,
  output out_item_t  out_data_o
);
  logic [RrpvW-1:0] rrpv_q [Ways];
  logic [Ways-1:0]  valid_q, hot_q;
  logic [3:0]       tier_q [Ways];
  logic [3:0]       hint_q [Ways];
  logic [WayW-1:0]  ptr_q;
  logic [1:0]       mode_q;
  logic [2:0]       bits_q;
  in_item_t         item_q;
  out_item_t        res_q;
  logic [WayW-1:0]  victim_q, scan_q;
  logic             inval_q;
  // ranked scan running best
  logic             bfound_q;
  logic [3:0]       bhint_q, btier_q;

  logic [RrpvW-1:0] mx;
  logic [2:0]       bclamp;
  always_comb begin
    bclamp = bits_q;
    if (bclamp < 3'd1) bclamp = 3'd1;
    if (bclamp > 3'd4) bclamp = 3'd4;
    mx = RrpvW'((5'd1 << bclamp) - 5'd1);
  end

  logic             ranked, by_hint;
  assign ranked  = mode_q[1];
  assign by_hint = (mode_q == MODE_HINT);

  // first invalid way
  logic [WayW-1:0] first_inv;
  logic            any_inv;
  always_comb begin
    first_inv = '0;
    any_inv   = 1'b0;
    for (int w = Ways - 1; w >= 0; w--) begin
      if (!valid_q[w]) begin
        first_inv = WayW'(w);
        any_inv   = 1'b1;
      end
    end
  end

  // scan probe
  logic [WayW-1:0] probe;
  logic            pmax, better, last;
  assign probe = ranked ? scan_q : ptr_q;
  assign pmax  = rrpv_q[probe] >= mx;
  assign last  = (scan_q == WayW'(Ways - 1));
  always_comb begin
    better = 1'b0;
    if (pmax) begin
      if (!bfound_q) better = 1'b1;
      else if (by_hint && hint_q[probe] > bhint_q) better = 1'b1;
      else if ((!by_hint || hint_q[probe] == bhint_q) && tier_q[probe] > btier_q)
        better = 1'b1;
    end
  end

  assign sts_o.is_fill   = (item_q.opcode == OP_FILL);
  assign sts_o.has_inval = any_inv;
  assign sts_o.found     = ranked ? (last && (bfound_q || pmax)) : pmax;
  assign sts_o.scan_end  = last;

  // insertion value
  logic [RrpvW-1:0] tv, ins, cv;
  logic [3:0]       hint_in;
  logic [7:0]       prod;
  logic [3:0]       pv;
  logic [4:0]       csum;
  always_comb begin
    hint_in = item_q.is_property ? item_q.reuse_hint : 4'd0;
    tv = mx;
    if (item_q.is_property) begin
      if (item_q.grasp_tier == 2'd1) tv = RrpvW'(1);
      else if (item_q.grasp_tier == 2'd2) tv = mx - RrpvW'(1);
    end
    prod = hint_in * mx;
    // floor(prod / 15) for prod <= 225
    pv   = 4'((16'(prod) * 16'd137) >> 11);
    csum = (5'(tv) + 5'(pv)) >> 1;
    cv   = csum[3:0];
    if (cv == '0 && tv != '0) cv = RrpvW'(1);
    if (cv > mx) cv = mx;
    ins = (mode_q == MODE_COMB) ? cv : tv;
  end

  logic [WayW-1:0] vway;
  assign vway = inval_q ? first_inv : victim_q;

  logic hit_ok;
  assign hit_ok = item_q.opcode == OP_HIT && 32'(item_q.target_way) < Ways;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hot_q   <= '0;
      ptr_q   <= '0;
      mode_q  <= MODE_DEGREE;
      bits_q  <= 3'd2;
      for (int w = 0; w < Ways; w++) begin
        tier_q[w] <= '0;
        hint_q[w] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_MODE) mode_q <= cfg_wdata_i[1:0];
        else bits_q <= cfg_wdata_i[2:0];
      end
      if (cmd_i.exec && item_q.opcode == OP_INVAL && 32'(item_q.target_way) < Ways)
        valid_q[WayW'(item_q.target_way)] <= 1'b0;
      if (cmd_i.scan && !ranked) ptr_q <= ptr_q + WayW'(1);
      if (cmd_i.write) begin
        valid_q[vway] <= 1'b1;
        tier_q[vway]  <= item_q.degree_tier;
        hint_q[vway]  <= hint_in;
        hot_q[vway]   <= item_q.is_property && item_q.grasp_tier == 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_data_i;
    if (cmd_i.exec) begin
      res_q.chosen_way  <= item_q.target_way;
      res_q.was_invalid <= 1'b0;
      res_q.prior_rrpv  <= hit_ok ? rrpv_q[WayW'(item_q.target_way)] : '0;
      inval_q  <= any_inv;
      scan_q   <= '0;
      bfound_q <= 1'b0;
      if (hit_ok) begin
        if (mode_q == MODE_COMB || hot_q[WayW'(item_q.target_way)])
          rrpv_q[WayW'(item_q.target_way)] <= '0;
        else if (rrpv_q[WayW'(item_q.target_way)] != '0)
          rrpv_q[WayW'(item_q.target_way)] <= rrpv_q[WayW'(item_q.target_way)] - 1'b1;
      end
    end
    if (cmd_i.scan) begin
      scan_q <= last ? '0 : scan_q + WayW'(1);
      if (!ranked) victim_q <= ptr_q;
      else if (better) begin
        bfound_q <= 1'b1;
        victim_q <= probe;
        bhint_q  <= hint_q[probe];
        btier_q  <= tier_q[probe];
      end
    end
    if (cmd_i.age)
      for (int w = 0; w < Ways; w++)
        if (rrpv_q[w] < mx) rrpv_q[w] <= rrpv_q[w] + 1'b1;
    if (cmd_i.write) begin
      rrpv_q[vway]      <= ins;
      res_q.chosen_way  <= 4'(vway);
      res_q.was_invalid <= inval_q;
    end
  end

  assign out_data_o = res_q;
endmodule

>>> src/tiered_rrip_victim_select_core.sv
// Top level: RRIP replacement engine for one cache set.
// Usage:
//   in_ch   - one transfer per request: hit, fill or invalidate of a way.
//   out_ch  - one transfer per request: chosen way, invalid flag, prior RRPV.
//   cfg_ch  - register writes (index 0 policy_mode, 1 rrpv_bits); write
//             only while idle; always ready.
// Sequencing: one request in flight. Hit, invalidate: EXEC, then OUT.
//   Fill into an invalid way: EXEC, WRITE, OUT. Fill with eviction: EXEC,
//   then SCAN probes and AGE steps, WRITE, OUT; the probe unit checks one
//   way per cycle, pointer modes stop at the first maximum way, ranked
//   modes sweep all 16 ways. Worst case, rrpv_bits=4 and all ways at zero:
//   16 sweeps and 15 aging steps. The next request is taken the cycle
//   after the result transfer.
// Reset: valid, hot, tier, hint tables and pointer clear; RRPV contents
//   are undefined until a fill writes them. policy_mode=2, rrpv_bits=2.
// Stall: the result is held in its register until out ready; no new
//   request is accepted meanwhile.
`timescale 1ns / 1ps
module tiered_rrip_victim_select_core import trvs_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  trvs_in_if.sink   in_ch,
  trvs_out_if.source out_ch,
  trvs_cfg_if.sink  cfg_ch
);
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  trvs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  trvs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_ch.valid),
    .cfg_index_i (cfg_ch.index),
    .cfg_wdata_i (cfg_ch.wdata),
    .in_data_i   (in_ch.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_ch.data)
  );
endmodule

>>> src/trvs_checker.sv
// Checker: port-level properties of the victim select block, with bind.
`timescale 1ns / 1ps
module trvs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [3:0] chosen_way_i,
  input logic       was_invalid_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(chosen_way_i) &&
      $stable(was_invalid_i))
    else $error("result changed while stalled");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("accepting while result pending");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !out_valid_i)
    else $error("result too early");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |=> !out_valid_i)
    else $error("result repeated");
endmodule

bind tiered_rrip_victim_select_core trvs_checker u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_ch.valid),
  .in_ready_i    (in_ch.ready),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .chosen_way_i  (out_ch.data.chosen_way),
  .was_invalid_i (out_ch.data.was_invalid)
);

>>> bench/tb_top.sv
// Testbench for the RRIP victim select core: directed table, then random phases.
`timescale 1ns / 1ps
module tb_top;
  import trvs_pkg::*;

  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned HoldCycles = 400;

  logic clk_i = 1'b0;
  logic rst_ni;
  always #2 clk_i = ~clk_i;

  trvs_in_if  in_ch ();
  trvs_out_if out_ch ();
  trvs_cfg_if cfg_ch ();

  tiered_rrip_victim_select_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow copy of the set state and registers.
  logic [3:0] rrpv_sh [Ways];
  logic       valid_sh [Ways];
  logic [3:0] tier_sh [Ways];
  logic [3:0] hint_sh [Ways];
  logic       hot_sh [Ways];
  logic       filled_once [Ways];   // ways whose RRPV has been written
  logic [3:0] scan_ptr;
  logic [1:0] mode_sh;
  logic [2:0] bits_sh;

  out_item_t  result_q [$];
  int unsigned mismatches = 0;
  int unsigned idle_cnt = 0;
  int unsigned hold_req = 0;
  bit          calm = 1'b0;        // no random stalls on either side

  function automatic int unsigned rrpv_max();
    int unsigned b;
    b = bits_sh;
    if (b < 1) b = 1;
    if (b > 4) b = 4;
    return (1 << b) - 1;
  endfunction

  task automatic age_ways(input int unsigned mx);
    for (int w = 0; w < Ways; w++)
      if (rrpv_sh[w] < mx) rrpv_sh[w] = rrpv_sh[w] + 4'd1;
  endtask

  task automatic pointer_pick(input int unsigned mx, output int unsigned v);
    int unsigned p;
    v = 0;
    for (int r = 0; r <= 16; r++) begin
      for (int k = 0; k < Ways; k++) begin
        p = scan_ptr;
        scan_ptr = scan_ptr + 4'd1;
        if (rrpv_sh[p] >= mx) begin
          v = p;
          return;
        end
      end
      age_ways(mx);
    end
  endtask

  // Ranked pick: optionally highest hint first, then highest degree tier.
  task automatic ranked_pick(input int unsigned mx, input bit by_hint, output int unsigned v);
    bit any, found;
    int unsigned top_hint, best_tier;
    v = 0;
    for (int r = 0; r <= 16; r++) begin
      any = 0;
      top_hint = 0;
      for (int w = 0; w < Ways; w++)
        if (rrpv_sh[w] >= mx) begin
          any = 1;
          if (hint_sh[w] > top_hint) top_hint = hint_sh[w];
        end
      if (any) begin
        found = 0;
        best_tier = 0;
        for (int w = 0; w < Ways; w++) begin
          if (rrpv_sh[w] < mx) continue;
          if (by_hint && hint_sh[w] != top_hint) continue;
          if (!found || tier_sh[w] > best_tier) begin
            found = 1;
            v = w;
            best_tier = tier_sh[w];
          end
        end
        return;
      end
      age_ways(mx);
    end
  endtask

  function automatic int unsigned insert_rrpv(input int unsigned mx, input bit prop,
                                              input logic [1:0] gt, input int unsigned hint);
    int unsigned tv, pv, c;
    tv = mx;
    if (prop) begin
      if (gt == 2'd1) tv = 1;
      else if (gt == 2'd2) tv = mx - 1;
    end
    if (mode_sh == MODE_COMB) begin
      pv = (hint * mx) / 15;
      c = (tv + pv) / 2;
      if (c == 0 && tv > 0) c = 1;
      return (c < mx) ? c : mx;
    end
    return tv;
  endfunction

  task automatic predict_outcome(input in_item_t it, output out_item_t r);
    int unsigned mx, v, hint;
    mx = rrpv_max();
    r = '0;
    r.chosen_way = it.target_way;
    case (it.opcode)
      OP_HIT: begin
        r.prior_rrpv = rrpv_sh[it.target_way];
        if (mode_sh == MODE_COMB || hot_sh[it.target_way]) rrpv_sh[it.target_way] = '0;
        else if (rrpv_sh[it.target_way] > 0)
          rrpv_sh[it.target_way] = rrpv_sh[it.target_way] - 4'd1;
      end
      OP_FILL: begin
        hint = it.is_property ? it.reuse_hint : 0;
        v = Ways;
        for (int w = Ways - 1; w >= 0; w--)
          if (!valid_sh[w]) v = w;
        if (v < Ways) r.was_invalid = 1'b1;
        else if (mode_sh == MODE_PTR || mode_sh == MODE_COMB) pointer_pick(mx, v);
        else ranked_pick(mx, mode_sh == MODE_HINT, v);
        valid_sh[v] = 1'b1;
        tier_sh[v] = it.degree_tier;
        hint_sh[v] = hint[3:0];
        hot_sh[v] = it.is_property && it.grasp_tier == 2'd1;
        rrpv_sh[v] = 4'(insert_rrpv(mx, it.is_property, it.grasp_tier, hint));
        filled_once[v] = 1'b1;
        r.chosen_way = v[3:0];
      end
      OP_INVAL: valid_sh[it.target_way] = 1'b0;
      default: ;
    endcase
  endtask

  // Sender side: item stays valid until a transfer; next item may follow directly.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
    out_item_t r;
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_outcome(it, r);
    result_q.push_back(typed ? typed_res : r);
  endtask

  task automatic sender_gap();
    int unsigned g, pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 60) return;
    g = (pick < 92) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    in_ch.valid <= 1'b0;
    repeat (g) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_MODE) mode_sh = val[1:0];
    else bits_sh = val[2:0];
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    int unsigned pick, n;
    it = in_item_t'($bits(in_item_t)'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 45) it.opcode = OP_FILL;
    else if (pick < 80) it.opcode = OP_HIT;
    else if (pick < 93) it.opcode = OP_INVAL;
    else it.opcode = OP_NONE;
    if (it.opcode == OP_HIT && !filled_once[it.target_way]) begin
      // only hit ways whose RRPV exists
      n = 0;
      for (int w = 0; w < Ways; w++) if (filled_once[w]) n++;
      if (n == 0) it.opcode = OP_FILL;
      else begin
        n = $urandom_range(0, n - 1);
        for (int w = 0; w < Ways; w++)
          if (filled_once[w]) begin
            if (n == 0) it.target_way = 4'(w);
            n--;
          end
      end
    end
    return it;
  endfunction

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  function automatic dir_row_t mk_row(input opcode_e op, input int unsigned tw,
                                      input int unsigned prop, input int unsigned gt,
                                      input int unsigned dt, input int unsigned rh,
                                      input int unsigned typed, input int unsigned cw,
                                      input int unsigned inv);
    dir_row_t d;
    d.it.opcode = op;
    d.it.target_way = 4'(tw);
    d.it.is_property = 1'(prop);
    d.it.grasp_tier = 2'(gt);
    d.it.degree_tier = 4'(dt);
    d.it.reuse_hint = 4'(rh);
    d.typed = 1'(typed);
    d.res.chosen_way = 4'(cw);
    d.res.was_invalid = 1'(inv);
    d.res.prior_rrpv = '0;
    return d;
  endfunction

  // Receiver with random stalls, one long hold-off on request, and result check.
  int unsigned stall_cnt = 0;
  int unsigned hold_seen = 0;
  out_item_t   want;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_cnt <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_ch.data);
        end else begin
          want = result_q.pop_front();
          if (out_ch.data.chosen_way !== want.chosen_way ||
              out_ch.data.was_invalid !== want.was_invalid ||
              out_ch.data.prior_rrpv !== want.prior_rrpv) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp way %0d inv %0d prior %0d, got way %0d inv %0d prior %0d",
                       want.chosen_way, want.was_invalid, want.prior_rrpv,
                       out_ch.data.chosen_way, out_ch.data.was_invalid,
                       out_ch.data.prior_rrpv);
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        stall_cnt <= HoldCycles;
        out_ch.ready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        out_ch.ready <= 1'b0;
      end else if (calm || $urandom_range(0, 99) < 70) begin
        out_ch.ready <= 1'b1;
      end else begin
        stall_cnt <= ($urandom_range(0, 9) < 9) ? $urandom_range(1, 4) : $urandom_range(15, 80);
        out_ch.ready <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cnt <= 0;
    else if (rst_ni) begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IdleLimit) begin
        $display("FAIL tiered_rrip_victim_select_core");
        $finish;
      end
    end
  end

  dir_row_t dir_tab [$];
  int unsigned phase_mode [10] = '{0, 1, 2, 3, 0, 1, 2, 3, 3, 2};
  int unsigned phase_bits [10] = '{1, 4, 4, 1, 0, 7, 3, 4, 2, 1};

  initial begin
    rst_ni = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_MODE;
    cfg_ch.wdata <= '0;
    for (int w = 0; w < Ways; w++) begin
      rrpv_sh[w] = '0; valid_sh[w] = 0; tier_sh[w] = '0;
      hint_sh[w] = '0; hot_sh[w] = 0; filled_once[w] = 0;
    end
    scan_ptr = '0;
    mode_sh = MODE_DEGREE;
    bits_sh = 3'd2;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: reset defaults, extremes, unused opcode, hot hit, invalid-way hit.
    dir_tab.push_back(mk_row(OP_FILL, 0, 1, 1, 15, 15, 1, 0, 1));
    dir_tab.push_back(mk_row(OP_NONE, 15, 1, 3, 15, 15, 1, 15, 0));
    dir_tab.push_back(mk_row(OP_INVAL, 15, 0, 0, 0, 0, 1, 15, 0));
    for (int i = 1; i < 16; i++)
      dir_tab.push_back(mk_row(OP_FILL, 15 - i, i % 2, i % 4, i, 15 - i, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_HIT, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_HIT, 1, 1, 1, 15, 15, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_FILL, 9, 0, 0, 15, 15, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_INVAL, 3, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_HIT, 3, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_FILL, 0, 1, 2, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_NONE, 0, 0, 0, 0, 0, 1, 0, 0));
    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);
      sender_gap();
    end
    drain();

    // Random phases over register settings, extremes and stale RRPVs included.
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CFG_MODE, phase_mode[ph]);
      write_reg(CFG_BITS, phase_bits[ph]);
      calm = (ph == 4);
      if (ph == 2) hold_req = hold_req + 1;   // long receiver hold-off, input backs up
      for (int n = 0; n < 190; n++) begin
        send_item(random_item(), 1'b0, '0);
        sender_gap();
      end
      drain();
    end

    if (mismatches == 0 && result_q.size() == 0) begin
      $display("PASS tiered_rrip_victim_select_core");
    end else begin
      $display("FAIL tiered_rrip_victim_select_core");
    end
    $finish;
  end
endmodule

>>> files.f
src/trvs_pkg.sv
src/trvs_if.sv
src/trvs_ctrl.sv
src/trvs_dp.sv
src/tiered_rrip_victim_select_core.sv
src/trvs_checker.sv
bench/tb_top.sv
